// File: hw/rtl/utf16be_to_utf8_transcoder_assert.svh
// assertion macros for the utf16be to utf8 transcoder
// needs a clock named aclk and an active-low reset named aresetn in scope
`ifndef UTF16BE_TO_UTF8_TRANSCODER_ASSERT_SVH
`define UTF16BE_TO_UTF8_TRANSCODER_ASSERT_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define U16_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("transcoder assertion failed");
// next-cycle implication
`define U16_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("transcoder assertion failed");
`else
`define U16_ASSERT_NOW(label, ante, cons)
`define U16_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// File: hw/rtl/u16u8_pkg.sv
// shared types and constants of the utf16be to utf8 transcoder
// no dependencies
package u16u8_pkg;

    // stop causes
    localparam logic [2:0] CAUSE_NONE      = 3'd0;
    localparam logic [2:0] CAUSE_NUL       = 3'd1;
    localparam logic [2:0] CAUSE_UNPAIRED  = 3'd2;
    localparam logic [2:0] CAUSE_LONE_LOW  = 3'd3;
    localparam logic [2:0] CAUSE_HIGH_END  = 3'd4;

    // top six bits of a surrogate unit
    localparam logic [5:0] HIGH_SURR_TAG = 6'b110110;
    localparam logic [5:0] LOW_SURR_TAG  = 6'b110111;

    // supplementary plane offset
    localparam logic [20:0] SUPP_BASE = 21'h10000;

    // utf-8 lead and continuation prefixes
    localparam logic [7:0] LEAD2 = 8'hC0;
    localparam logic [7:0] LEAD3 = 8'hE0;
    localparam logic [7:0] LEAD4 = 8'hF0;
    localparam logic [7:0] CONT  = 8'h80;

    // up to four utf-8 bytes per input byte
    localparam int MAX_BYTES = 4;

    // results of one input byte, first byte at index 0
    typedef struct packed {
        logic [2:0]                  count;
        logic [MAX_BYTES-1:0][7:0]   bytes;
        logic                        present;
        logic                        done;
        logic [2:0]                  cause;
    } conv_result_t;

    // result buffer status toward the input side
    typedef struct packed {
        logic       room;
        logic [2:0] level;
    } emit_status_t;

endpackage

// File: hw/rtl/u16u8_conv.sv
// conversion state and single-pass decode of one utf16be byte
// depends on u16u8_pkg
module u16u8_conv (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     in_take,
    input  logic [7:0]               in_byte,
    input  logic                     in_last,
    output u16u8_pkg::conv_result_t  res
);

    typedef struct packed {
        logic       odd_phase;
        logic [7:0] held_high;
        logic       pending;
        logic [9:0] high_bits;
        logic       stopped;
        logic [2:0] reason;
    } conv_state_t;

    conv_state_t st_reg;
    conv_state_t st_next;
    conv_state_t st_work;
    logic [15:0] unit;
    logic [20:0] code_point;
    logic        emit;

    // unit decode and surrogate handling
    always_comb begin
        st_work    = st_reg;
        unit       = {st_reg.held_high, in_byte};
        code_point = {5'd0, unit};
        emit       = 1'b0;
        if (!st_reg.stopped) begin
            if (!st_reg.odd_phase) begin
                st_work.held_high = in_byte;
                st_work.odd_phase = 1'b1;
            end else begin
                st_work.odd_phase = 1'b0;
                if (st_reg.pending) begin
                    if (unit[15:10] == u16u8_pkg::LOW_SURR_TAG) begin
                        code_point      = u16u8_pkg::SUPP_BASE
                                        + {1'b0, st_reg.high_bits, unit[9:0]};
                        st_work.pending = 1'b0;
                        emit            = 1'b1;
                    end else begin
                        st_work.stopped = 1'b1;
                        st_work.reason  = u16u8_pkg::CAUSE_UNPAIRED;
                        st_work.pending = 1'b0;
                    end
                end else if (unit == 16'd0) begin
                    st_work.stopped = 1'b1;
                    st_work.reason  = u16u8_pkg::CAUSE_NUL;
                end else if (unit[15:10] == u16u8_pkg::HIGH_SURR_TAG) begin
                    st_work.pending   = 1'b1;
                    st_work.high_bits = unit[9:0];
                end else if (unit[15:10] == u16u8_pkg::LOW_SURR_TAG) begin
                    st_work.stopped = 1'b1;
                    st_work.reason  = u16u8_pkg::CAUSE_LONE_LOW;
                end else begin
                    emit = 1'b1;
                end
            end
            // high surrogate still open at the end of the field
            if (in_last && st_work.pending) begin
                st_work.stopped = 1'b1;
                st_work.reason  = u16u8_pkg::CAUSE_HIGH_END;
                st_work.pending = 1'b0;
            end
        end
    end

    // utf-8 encoding and end marker
    always_comb begin
        res         = '0;
        res.present = 1'b1;
        if (emit) begin
            priority if (code_point[20:7] == 14'd0) begin
                res.count    = 3'd1;
                res.bytes[0] = {1'b0, code_point[6:0]};
            end else if (code_point[20:11] == 10'd0) begin
                res.count    = 3'd2;
                res.bytes[0] = u16u8_pkg::LEAD2 | {3'd0, code_point[10:6]};
                res.bytes[1] = u16u8_pkg::CONT  | {2'd0, code_point[5:0]};
            end else if (code_point[20:16] == 5'd0) begin
                res.count    = 3'd3;
                res.bytes[0] = u16u8_pkg::LEAD3 | {4'd0, code_point[15:12]};
                res.bytes[1] = u16u8_pkg::CONT  | {2'd0, code_point[11:6]};
                res.bytes[2] = u16u8_pkg::CONT  | {2'd0, code_point[5:0]};
            end else begin
                res.count    = 3'd4;
                res.bytes[0] = u16u8_pkg::LEAD4 | {5'd0, code_point[20:18]};
                res.bytes[1] = u16u8_pkg::CONT  | {2'd0, code_point[17:12]};
                res.bytes[2] = u16u8_pkg::CONT  | {2'd0, code_point[11:6]};
                res.bytes[3] = u16u8_pkg::CONT  | {2'd0, code_point[5:0]};
            end
        end else if (in_last) begin
            res.count   = 3'd1;
            res.present = 1'b0;
        end
        if (in_last) begin
            res.done  = 1'b1;
            res.cause = st_work.stopped ? st_work.reason : u16u8_pkg::CAUSE_NONE;
        end
    end

    // state returns to reset after the last byte of a field
    always_comb begin
        st_next = st_reg;
        if (in_take) begin
            st_next = in_last ? '0 : st_work;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= '0;
        end else begin
            st_reg <= st_next;
        end
    end

endmodule

// File: hw/rtl/u16u8_emit.sv
// result buffer that sends the utf-8 bytes of one input byte one per transfer
// depends on u16u8_pkg
module u16u8_emit (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     load,
    input  u16u8_pkg::conv_result_t  res,
    input  logic                     m_ready,
    output logic                     m_valid,
    output logic [7:0]               m_utf8_byte,
    output logic                     m_byte_present,
    output logic                     m_run_last,
    output logic                     m_text_done,
    output logic [2:0]               m_stop_cause,
    output u16u8_pkg::emit_status_t  status
);

    logic [2:0]                                cnt_reg;
    logic [2:0]                                cnt_next;
    logic [u16u8_pkg::MAX_BYTES-1:0][7:0]      data_reg;
    logic [u16u8_pkg::MAX_BYTES-1:0][7:0]      data_next;
    logic                                      present_reg;
    logic                                      present_next;
    logic                                      done_reg;
    logic                                      done_next;
    logic [2:0]                                cause_reg;
    logic [2:0]                                cause_next;
    logic                                      pop;
    logic                                      final_one;

    // output side
    assign pop            = m_valid && m_ready;
    assign final_one      = (cnt_reg == 3'd1);
    assign m_valid        = (cnt_reg != 3'd0);
    assign m_utf8_byte    = data_reg[0];
    assign m_byte_present = present_reg;
    assign m_run_last     = final_one;
    assign m_text_done    = final_one && done_reg;
    assign m_stop_cause   = final_one ? cause_reg : u16u8_pkg::CAUSE_NONE;

    // a new load is allowed once the last buffered byte leaves this cycle
    assign status.room  = (cnt_reg == 3'd0) || (final_one && m_ready);
    assign status.level = cnt_reg;

    // load or shift
    always_comb begin
        cnt_next     = cnt_reg;
        data_next    = data_reg;
        present_next = present_reg;
        done_next    = done_reg;
        cause_next   = cause_reg;
        if (load) begin
            cnt_next     = res.count;
            data_next    = res.bytes;
            present_next = res.present;
            done_next    = res.done;
            cause_next   = res.cause;
        end else if (pop) begin
            cnt_next  = cnt_reg - 3'd1;
            data_next = {8'd0, data_reg[u16u8_pkg::MAX_BYTES-1:1]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 3'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
        data_reg    <= data_next;
        present_reg <= present_next;
        done_reg    <= done_next;
        cause_reg   <= cause_next;
    end

endmodule

// File: hw/rtl/utf16be_to_utf8_transcoder.sv
// top level of the utf16be to utf8 transcoder
// depends on u16u8_pkg, u16u8_conv, u16u8_emit and the assertion macro header
//
// Usage:
//   The input channel (s_valid, s_ready, s_text_byte, s_field_end) takes a
//   text field one byte per transfer, high byte of each 16-bit unit first;
//   s_field_end marks the last byte of the field.
//   The result channel (m_valid, m_ready, m_utf8_byte, m_byte_present,
//   m_run_last, m_text_done, m_stop_cause) gives the utf-8 bytes, one per
//   transfer. m_run_last flags the last result of an input byte,
//   m_text_done the final result of the field, which also carries the stop
//   cause. A bare end marker has m_byte_present low.
//   The first result of a byte is offered the cycle after that byte is
//   taken. Throughput: one input byte per cycle while each byte gives at
//   most one result and m_ready is high; a byte that gives several results
//   holds the input until its last result leaves the single result buffer,
//   which is drained one byte a cycle while m_ready is high.
//   Reset (aresetn low at a clock edge) empties the result buffer and
//   returns the converter to the start of a field.
//   When the receiver stalls, the current result holds and s_ready stays
//   low as long as the buffer holds any byte.
`include "utf16be_to_utf8_transcoder_assert.svh"
module utf16be_to_utf8_transcoder (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_text_byte,
    input  logic       s_field_end,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_utf8_byte,
    output logic       m_byte_present,
    output logic       m_run_last,
    output logic       m_text_done,
    output logic [2:0] m_stop_cause
);

    u16u8_pkg::conv_result_t res;
    u16u8_pkg::emit_status_t status;
    logic                    take;

    // input transfer
    assign s_ready = status.room;
    assign take    = s_valid && s_ready;

    // decode and state
    u16u8_conv u_conv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_take (take),
        .in_byte (s_text_byte),
        .in_last (s_field_end),
        .res     (res)
    );

    // result buffer
    u16u8_emit u_emit (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .load           (take),
        .res            (res),
        .m_ready        (m_ready),
        .m_valid        (m_valid),
        .m_utf8_byte    (m_utf8_byte),
        .m_byte_present (m_byte_present),
        .m_run_last     (m_run_last),
        .m_text_done    (m_text_done),
        .m_stop_cause   (m_stop_cause),
        .status         (status)
    );

    // checks
    `U16_ASSERT_NEXT(a_end_gives_result, s_valid && s_ready && s_field_end, m_valid)
    `U16_ASSERT_NOW(a_ready_has_room, s_ready, status.level <= 3'd1)
    `U16_ASSERT_NOW(a_cause_only_at_end, m_valid && (m_stop_cause != u16u8_pkg::CAUSE_NONE), m_text_done)
    `U16_ASSERT_NOW(a_marker_is_final, m_valid && !m_byte_present, m_run_last && m_text_done)

endmodule
